>>> rtl/rolling_adler_window_checksum_macros.svh
// ----------------------------------------------------------------------------
// Rolling Adler window checksum: assertion macros
// Shared property shorthands for the checker of the rolling checksum block.
// ----------------------------------------------------------------------------
`ifndef ROLLING_ADLER_WINDOW_CHECKSUM_MACROS_SVH
`define ROLLING_ADLER_WINDOW_CHECKSUM_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define RAWC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, muted while reset is asserted.
`define RAWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rawc_pkg.sv
// ----------------------------------------------------------------------------
// rawc_pkg
// Widths, defaults and the control bundle shared by the rolling checksum block.
// ----------------------------------------------------------------------------
package rawc_pkg;

	localparam int CFG_W           = 13;
	localparam int BYTE_W          = 8;
	localparam int SUM_W           = 16;
	localparam int CHK_W           = 2 * SUM_W;
	localparam int DEF_MAX_WINDOW  = 4096;
	localparam int DEF_SUM_MODULUS = 65521;
	localparam int RESET_WINDOW    = 1024;

	// Per-item control that travels down the sum pipeline.
	typedef struct packed {
		logic valid;
		logic restart;
		logic roll;
		logic full;
	} rawc_ctl_t;

endpackage

>>> rtl/rawc_if.sv
// ----------------------------------------------------------------------------
// rawc_if
// Valid/ready channels for the byte stream and the checksum results.
// ----------------------------------------------------------------------------
interface rawc_byte_if;
	logic                       valid;
	logic                       ready;
	logic [rawc_pkg::BYTE_W-1:0] data_byte;
	logic                       restart;

	modport source(output valid, data_byte, restart, input ready);
	modport sink(input valid, data_byte, restart, output ready);
endinterface

interface rawc_sum_if;
	logic                       valid;
	logic                       ready;
	logic [rawc_pkg::CHK_W-1:0] checksum;
	logic                       window_full;

	modport source(output valid, checksum, window_full, input ready);
	modport sink(input valid, checksum, window_full, output ready);
endinterface

>>> rtl/rolling_adler_window_checksum.sv
// ----------------------------------------------------------------------------
// rolling_adler_window_checksum
// Rolling Adler-32 over the last window_length bytes of a byte stream.
// ----------------------------------------------------------------------------
//  channel    role    payload                         transfer when
//  byte_ch    sink    data_byte[7:0], restart         valid && ready
//  sum_ch     source  checksum[31:16|15:0], window_full  valid && ready
//  cfg_wr_*   write   window_length[12:0]             cfg_wr_en
//
//  One byte per cycle while advance is high.
//  The whole pipeline moves as one on advance, which is low only while a
//  result sits in the output register and the sink holds ready low.
//  The per-cycle limit is the low/high sum register loop in the last stage.
//  Reset clears pointer, fill count and sums; the ring store is not cleared
//  and needs no clearing pass: a roll only reads slots written before it.
// ----------------------------------------------------------------------------
module rolling_adler_window_checksum #(
	parameter int MAX_WINDOW  = rawc_pkg::DEF_MAX_WINDOW,
	parameter int SUM_MODULUS = rawc_pkg::DEF_SUM_MODULUS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	rawc_byte_if.sink                  byte_ch,
	rawc_sum_if.source                 sum_ch,
	input  logic                       cfg_wr_en,
	input  logic [rawc_pkg::CFG_W-1:0] cfg_wr_data
);

	localparam int AW        = $clog2(MAX_WINDOW);
	localparam int LW        = $clog2(MAX_WINDOW + 1);
	localparam int RESET_LEN = (rawc_pkg::RESET_WINDOW > MAX_WINDOW)
	                         ? MAX_WINDOW : rawc_pkg::RESET_WINDOW;

	logic                        advance;
	logic                        accept;
	logic [LW-1:0]               win_len_q;
	logic [AW-1:0]               wr_addr;
	logic [AW-1:0]               rd_addr;
	logic [rawc_pkg::BYTE_W-1:0] old_s1;
	logic [rawc_pkg::BYTE_W-1:0] data_s1;
	rawc_pkg::rawc_ctl_t         ctl_s1;
	logic                        res_valid;

	// Advance whenever the output register is empty or is being drained.
	assign advance       = !res_valid || sum_ch.ready;
	assign accept        = byte_ch.valid && advance;
	assign byte_ch.ready = advance;
	assign sum_ch.valid  = res_valid;

	// Hold the effective window length: zero acts as one, clamp at the ring size.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= LW'(RESET_LEN);
		end else if (cfg_wr_en) begin
			priority if (cfg_wr_data == '0) begin
				win_len_q <= LW'(1);
			end else if (int'(cfg_wr_data) > MAX_WINDOW) begin
				win_len_q <= LW'(MAX_WINDOW);
			end else begin
				win_len_q <= LW'(cfg_wr_data);
			end
		end
	end

	// Write the new byte and fetch the leaving one in the same cycle.
	rawc_ring_ctrl #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_ring_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.accept   (accept),
		.restart  (byte_ch.restart),
		.data_byte(byte_ch.data_byte),
		.win_len  (win_len_q),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.ctl_s1   (ctl_s1),
		.data_s1  (data_s1)
	);

	rawc_ring_mem #(
		.DEPTH(MAX_WINDOW)
	) u_ring_mem (
		.clk    (clk),
		.wr_en  (accept),
		.wr_addr(wr_addr),
		.wr_data(byte_ch.data_byte),
		.rd_en  (advance),
		.rd_addr(rd_addr),
		.rd_data(old_s1)
	);

	// Weight the leaving byte, then roll or extend both sums.
	rawc_sum_pipe #(
		.MAX_WINDOW (MAX_WINDOW),
		.SUM_MODULUS(SUM_MODULUS)
	) u_sum_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.ctl_s1     (ctl_s1),
		.data_s1    (data_s1),
		.old_s1     (old_s1),
		.win_len    (win_len_q),
		.res_valid  (res_valid),
		.checksum   (sum_ch.checksum),
		.window_full(sum_ch.window_full)
	);

endmodule

>>> rtl/rawc_ring_mem.sv
// ----------------------------------------------------------------------------
// rawc_ring_mem
// Byte ring store: one write port, one registered read port (read-first).
// ----------------------------------------------------------------------------
module rawc_ring_mem #(
	parameter int   DEPTH = rawc_pkg::DEF_MAX_WINDOW,
	localparam int  AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [rawc_pkg::BYTE_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [rawc_pkg::BYTE_W-1:0] rd_data
);

	logic [rawc_pkg::BYTE_W-1:0] mem [DEPTH];

	// A read and a write to the same slot in one cycle return the old byte.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/rawc_ring_ctrl.sv
// ----------------------------------------------------------------------------
// rawc_ring_ctrl
// Ring pointer and fill count; picks fill or roll and addresses the ring.
// ----------------------------------------------------------------------------
module rawc_ring_ctrl #(
	parameter int  MAX_WINDOW = rawc_pkg::DEF_MAX_WINDOW,
	localparam int AW         = $clog2(MAX_WINDOW),
	localparam int LW         = $clog2(MAX_WINDOW + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        accept,
	input  logic                        restart,
	input  logic [rawc_pkg::BYTE_W-1:0] data_byte,
	input  logic [LW-1:0]               win_len,
	output logic [AW-1:0]               wr_addr,
	output logic [AW-1:0]               rd_addr,
	output rawc_pkg::rawc_ctl_t         ctl_s1,
	output logic [rawc_pkg::BYTE_W-1:0] data_s1
);

	logic [AW-1:0] ptr_q;
	logic [LW-1:0] fill_q;
	logic [AW-1:0] ptr_cur;
	logic [AW-1:0] ptr_nxt;
	logic [LW-1:0] fill_cur;
	logic [LW-1:0] fill_nxt;
	logic          roll;
	logic [LW:0]   ptr_ext;
	logic [LW:0]   len_ext;
	logic [LW:0]   slot;

	// A restart clears pointer and fill count ahead of this byte.
	assign ptr_cur  = restart ? '0 : ptr_q;
	assign fill_cur = restart ? '0 : fill_q;
	assign roll     = (fill_cur >= win_len);
	assign fill_nxt = roll ? fill_cur : fill_cur + 1'b1;
	assign ptr_nxt  = (ptr_cur == AW'(MAX_WINDOW - 1)) ? '0 : ptr_cur + 1'b1;

	// Oldest byte sits win_len slots behind the write slot, wrapping the ring.
	assign ptr_ext = (LW + 1)'(ptr_cur);
	assign len_ext = (LW + 1)'(win_len);
	assign slot    = (ptr_ext >= len_ext) ? ptr_ext - len_ext
	                                      : ptr_ext + (LW + 1)'(MAX_WINDOW) - len_ext;
	assign rd_addr = slot[AW-1:0];
	assign wr_addr = ptr_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
			ctl_s1 <= '0;
		end else begin
			if (accept) begin
				ptr_q  <= ptr_nxt;
				fill_q <= fill_nxt;
			end
			if (advance) begin
				ctl_s1.valid   <= accept;
				ctl_s1.restart <= restart;
				ctl_s1.roll    <= roll;
				ctl_s1.full    <= (fill_nxt >= win_len);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s1 <= data_byte;
		end
	end

endmodule

>>> rtl/rawc_sum_pipe.sv
// ----------------------------------------------------------------------------
// rawc_sum_pipe
// Modular weighting of the leaving byte and the low/high sum update.
// ----------------------------------------------------------------------------
module rawc_sum_pipe #(
	parameter int  MAX_WINDOW  = rawc_pkg::DEF_MAX_WINDOW,
	parameter int  SUM_MODULUS = rawc_pkg::DEF_SUM_MODULUS,
	localparam int LW          = $clog2(MAX_WINDOW + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  rawc_pkg::rawc_ctl_t         ctl_s1,
	input  logic [rawc_pkg::BYTE_W-1:0] data_s1,
	input  logic [rawc_pkg::BYTE_W-1:0] old_s1,
	input  logic [LW-1:0]               win_len,
	output logic                        res_valid,
	output logic [rawc_pkg::CHK_W-1:0]  checksum,
	output logic                        window_full
);

	localparam int SW = rawc_pkg::SUM_W;
	localparam int PW = LW + rawc_pkg::BYTE_W;
	localparam int SH = PW + SW;
	localparam int RW = SH - $clog2(SUM_MODULUS) + 2;
	localparam int QW = PW + RW - SH;
	localparam int DW = PW + SW;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SH) + 64'(SUM_MODULUS) - 64'd1) / 64'(SUM_MODULUS);
	localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];
	localparam logic [SW-1:0] MOD   = SW'(SUM_MODULUS);

	// Stage 1: byte residues and the len * old product.
	logic [SW-1:0] new_ext;
	logic [SW-1:0] old_ext;
	logic [SW-1:0] new_res;
	logic [SW-1:0] old_res;
	logic [SW-1:0] delta;
	logic [PW-1:0] prod;

	assign new_ext = SW'(data_s1);
	assign old_ext = SW'(old_s1);
	assign new_res = (new_ext >= MOD) ? new_ext - MOD : new_ext;
	assign old_res = (old_ext >= MOD) ? old_ext - MOD : old_ext;
	assign delta   = !ctl_s1.roll ? new_res
	               : (new_res >= old_res) ? new_res - old_res : new_res + MOD - old_res;
	assign prod    = PW'(win_len) * PW'(old_s1);

	rawc_pkg::rawc_ctl_t ctl_s2;
	logic [SW-1:0]       delta_s2;
	logic [PW-1:0]       prod_s2;

	// Stage 2: quotient by reciprocal multiply (exact for this product range).
	logic [PW+RW-1:0] qprod;
	assign qprod = (PW + RW)'(prod_s2) * (PW + RW)'(RECIP);

	rawc_pkg::rawc_ctl_t ctl_s3;
	logic [SW-1:0]       delta_s3;
	logic [PW-1:0]       prod_s3;
	logic [QW-1:0]       quot_s3;

	// Stage 3: remainder, folded into the high-sum addend m - 1 - weighted.
	logic [RW-1:0] qm;
	logic [DW-1:0] rem;
	logic [SW-1:0] weighted;
	logic [SW-1:0] hadd;

	assign qm       = RW'(quot_s3) * RW'(SUM_MODULUS);
	assign rem      = DW'(prod_s3) - DW'(qm);
	assign weighted = rem[SW-1:0];
	assign hadd     = ctl_s3.roll ? (MOD - 1'b1) - weighted : '0;

	rawc_pkg::rawc_ctl_t ctl_s4;
	logic [SW-1:0]       delta_s4;
	logic [SW-1:0]       hadd_s4;

	// Stage 4: sum update; low_q/high_q close the sum register loop.
	logic [SW-1:0]   low_q;
	logic [SW-1:0]   high_q;
	logic [SW-1:0]   low_in;
	logic [SW-1:0]   high_in;
	logic [SW:0]     low_sum;
	logic [SW-1:0]   low_nxt;
	logic [SW+1:0]   high_sum;
	logic [SW-1:0]   high_nxt;

	assign low_in   = ctl_s4.restart ? SW'(1) : low_q;
	assign high_in  = ctl_s4.restart ? '0 : high_q;
	assign low_sum  = (SW + 1)'(low_in) + (SW + 1)'(delta_s4);
	assign low_nxt  = (low_sum >= (SW + 1)'(SUM_MODULUS))
	                ? SW'(low_sum - (SW + 1)'(SUM_MODULUS)) : SW'(low_sum);
	assign high_sum = (SW + 2)'(high_in) + (SW + 2)'(low_nxt) + (SW + 2)'(hadd_s4);

	always_comb begin
		priority if (high_sum >= (SW + 2)'(2 * SUM_MODULUS)) begin
			high_nxt = SW'(high_sum - (SW + 2)'(2 * SUM_MODULUS));
		end else if (high_sum >= (SW + 2)'(SUM_MODULUS)) begin
			high_nxt = SW'(high_sum - (SW + 2)'(SUM_MODULUS));
		end else begin
			high_nxt = SW'(high_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2    <= '0;
			ctl_s3    <= '0;
			ctl_s4    <= '0;
			low_q     <= SW'(1);
			high_q    <= '0;
			res_valid <= 1'b0;
		end else if (advance) begin
			ctl_s2    <= ctl_s1;
			ctl_s3    <= ctl_s2;
			ctl_s4    <= ctl_s3;
			res_valid <= ctl_s4.valid;
			if (ctl_s4.valid) begin
				low_q  <= low_nxt;
				high_q <= high_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			delta_s2 <= delta;
			prod_s2  <= prod;
			delta_s3 <= delta_s2;
			prod_s3  <= prod_s2;
			quot_s3  <= qprod[PW+RW-1:SH];
			delta_s4 <= delta_s3;
			hadd_s4  <= hadd;
			if (ctl_s4.valid) begin
				checksum    <= {high_nxt, low_nxt};
				window_full <= ctl_s4.full;
			end
		end
	end

endmodule

>>> rtl/rawc_checker.sv
// ----------------------------------------------------------------------------
// rawc_checker
// Port-level checks on the rolling checksum block, bound to its top level.
// ----------------------------------------------------------------------------
`include "rolling_adler_window_checksum_macros.svh"

module rawc_checker #(
	parameter int SUM_MODULUS = rawc_pkg::DEF_SUM_MODULUS
) (
	input logic        clk,
	input logic        arst_n,
	rawc_byte_if.sink  byte_ch,
	rawc_sum_if.source sum_ch
);

	localparam int SW = rawc_pkg::SUM_W;

	`RAWC_ASSERT_NEXT(a_result_held, clk, arst_n, sum_ch.valid && !sum_ch.ready, sum_ch.valid && $stable(sum_ch.checksum) && $stable(sum_ch.window_full), "stalled result changed or dropped")

	`RAWC_ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, !sum_ch.valid, byte_ch.ready, "input stalled with empty output")

	`RAWC_ASSERT_IMPLY(a_ready_when_drained, clk, arst_n, sum_ch.ready, byte_ch.ready, "input stalled while output drains")

	`RAWC_ASSERT_IMPLY(a_sums_reduced, clk, arst_n, sum_ch.valid, (sum_ch.checksum[SW-1:0] < SW'(SUM_MODULUS)) && (sum_ch.checksum[2*SW-1:SW] < SW'(SUM_MODULUS)), "sum not reduced below modulus")

endmodule

bind rolling_adler_window_checksum rawc_checker #(
	.SUM_MODULUS(SUM_MODULUS)
) u_rawc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.byte_ch(byte_ch),
	.sum_ch (sum_ch)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: rolling Adler window checksum testbench
// Streams bytes through the rolling checksum block and checks every checksum
// and window-full flag against a predictor kept in step with each transfer.
// ----------------------------------------------------------------------------
module tb_top;

	import rawc_pkg::*;

	localparam int RING_DEPTH = DEF_MAX_WINDOW;
	localparam int MODULUS    = DEF_SUM_MODULUS;
	localparam int MAX_SHOWN  = 10;

	typedef struct packed {
		logic [CHK_W-1:0] checksum;
		logic             window_full;
	} adler_result_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	rawc_byte_if byte_ch();
	rawc_sum_if  sum_ch();

	rolling_adler_window_checksum dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_ch     (byte_ch),
		.sum_ch      (sum_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #5 clk = ~clk;

	// Predictor state: a private copy of the ring, both sums, the fill count,
	// the write pointer and the window length register.
	logic [BYTE_W-1:0] ring_bytes [0:RING_DEPTH-1];
	int unsigned       low_acc;
	int unsigned       high_acc;
	logic [12:0]       bytes_filled;
	logic [11:0]       write_slot;
	logic [CFG_W-1:0]  window_setting;

	adler_result_t pending_sums[$];
	int unsigned   mismatch_count = 0;

	// Idling controls; the stimulus turns them off for the last part of the run.
	bit src_idling  = 1'b1;
	bit sink_idling = 1'b1;
	bit hold_request = 1'b0;

	// ------------------------------------------------------------------------
	// Predictor: advance the window by one byte and queue the expected result.
	// ------------------------------------------------------------------------
	task automatic push_expected_sum(input logic [BYTE_W-1:0] value, input logic restart_flag);
		int unsigned   span;
		int unsigned   slot;
		int unsigned   oldest;
		int unsigned   weighted;
		adler_result_t result;
		// Zero acts as one; anything above the ring depth saturates.
		span = window_setting;
		if (span == 0)
			span = 1;
		if (span > RING_DEPTH)
			span = RING_DEPTH;
		if (restart_flag) begin
			low_acc      = 1;
			high_acc     = 0;
			bytes_filled = '0;
			write_slot   = '0;
		end
		if (int'(bytes_filled) < span) begin
			// Still filling: plain Adler accumulate.
			low_acc      = (low_acc + value) % MODULUS;
			high_acc     = (high_acc + low_acc) % MODULUS;
			bytes_filled = bytes_filled + 1'b1;
		end else begin
			// Full: drop the byte span positions back, add the new one.
			slot     = (int'(write_slot) + RING_DEPTH - span) % RING_DEPTH;
			oldest   = ring_bytes[slot];
			weighted = (span * oldest) % MODULUS;
			low_acc  = (low_acc + MODULUS - oldest + value) % MODULUS;
			high_acc = (high_acc + MODULUS - weighted + low_acc + MODULUS - 1) % MODULUS;
		end
		ring_bytes[write_slot] = value;
		write_slot = write_slot + 1'b1;
		result.checksum    = {high_acc[SUM_W-1:0], low_acc[SUM_W-1:0]};
		result.window_full = (int'(bytes_filled) >= span);
		pending_sums.push_back(result);
	endtask

	task automatic flag_mismatch(input string what, input logic [CHK_W-1:0] want,
			input logic [CHK_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_SHOWN)
			$display("%0t: %s: expected %h, actual %h", $realtime, what, want, got);
	endtask

	// ------------------------------------------------------------------------
	// Result checker: compare each output transfer with the oldest expectation.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		adler_result_t want;
		if (arst_n && sum_ch.valid && sum_ch.ready) begin
			if (pending_sums.size() == 0) begin
				flag_mismatch("unexpected result", '0, sum_ch.checksum);
			end else begin
				want = pending_sums.pop_front();
				if (sum_ch.checksum !== want.checksum)
					flag_mismatch("checksum", want.checksum, sum_ch.checksum);
				if (sum_ch.window_full !== want.window_full)
					flag_mismatch("window_full", CHK_W'(want.window_full),
						CHK_W'(sum_ch.window_full));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: random stalls in bursts, plus one long hold-off on request.
	// ------------------------------------------------------------------------
	int stall_left = 0;
	int hold_left  = 0;

	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = 250;
		end
		if (!arst_n) begin
			sum_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			sum_ch.ready <= 1'b0;
		end else if (!sink_idling) begin
			sum_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			sum_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			sum_ch.ready <= 1'b0;
		end else begin
			sum_ch.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Sender. Entered and left at a falling edge. Valid stays high between
	// back-to-back transfers and drops only for an idle burst.
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [BYTE_W-1:0] value, input logic restart_flag);
		int gap;
		if (src_idling && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			byte_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= value;
		byte_ch.restart   <= restart_flag;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		push_expected_sum(value, restart_flag);
		@(negedge clk);
	endtask

	// Drop valid, wait for every expected result, then let the pipe settle.
	task automatic wait_for_idle();
		byte_ch.valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// Write the window length only with the block idle.
	task automatic write_window_length(input logic [CFG_W-1:0] value);
		wait_for_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		window_setting = value;
	endtask

	// Favor the byte extremes so the sums wrap the modulus often.
	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Byte extremes, restarts, zero and oversized lengths, and length changes
	// in the middle of a window, both shrinking below and growing above fill.
	task automatic test_directed_cases();
		int k;
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		// zero length behaves as one: every byte rolls
		write_window_length('0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		write_window_length(13'd1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h07, 1'b0);
		// all-ones length saturates to the ring depth
		write_window_length('1);
		send_byte(8'hC8, 1'b1);
		send_byte(8'hFF, 1'b0);
		write_window_length(CFG_W'(RING_DEPTH));
		send_byte(8'h01, 1'b0);
		// fill a short window and roll it with full-scale bytes
		write_window_length(13'd3);
		send_byte(8'hFF, 1'b1);
		for (k = 0; k < 5; k++)
			send_byte(8'hFF, 1'b0);
		// shrink below the fill count: keep rolling with the new length
		write_window_length(13'd2);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		// grow above the fill count: fill again without removal
		write_window_length(13'd6);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h09, 1'b0);
	endtask

	// Fill the default-sized window and roll well past it.
	task automatic test_default_length_roll();
		int k;
		write_window_length(CFG_W'(RESET_WINDOW));
		send_byte(pick_byte(), 1'b1);
		for (k = 0; k < 1100; k++)
			send_byte(pick_byte(), ($urandom_range(0, 499) == 0));
	endtask

	// Mostly short windows, plus zero, full and oversized lengths; phases with no
	// restart apply the new length to sums carried over from the previous phase.
	task automatic test_random_lengths();
		int               phase;
		int               k;
		logic [CFG_W-1:0] span;
		for (phase = 0; phase < 10; phase++) begin
			case ($urandom_range(0, 9))
				0:       span = '0;
				1:       span = '1;
				2:       span = CFG_W'($urandom_range(RING_DEPTH + 1, 8190));
				3:       span = CFG_W'(RING_DEPTH);
				default: span = CFG_W'($urandom_range(1, 48));
			endcase
			write_window_length(span);
			send_byte(pick_byte(), ($urandom_range(0, 1) == 1));
			for (k = 0; k < 39; k++)
				send_byte(pick_byte(), ($urandom_range(0, 24) == 0));
		end
	endtask

	// Hold the receiver off for a long stretch while bytes keep coming, so
	// the pipeline fills and stalls its input.
	task automatic test_output_backpressure();
		int k;
		write_window_length(13'd7);
		src_idling   = 1'b0;
		hold_request = 1'b1;
		send_byte(pick_byte(), 1'b1);
		for (k = 0; k < 39; k++)
			send_byte(pick_byte(), 1'b0);
		src_idling = 1'b1;
	endtask

	// Run at full rate on both sides.
	task automatic test_full_rate();
		int k;
		src_idling  = 1'b0;
		sink_idling = 1'b0;
		write_window_length(CFG_W'($urandom_range(1, 16)));
		send_byte(pick_byte(), 1'b1);
		for (k = 0; k < 80; k++)
			send_byte(pick_byte(), ($urandom_range(0, 29) == 0));
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_wr_data       = '0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.restart   = 1'b0;
		sum_ch.ready      = 1'b0;
		low_acc           = 1;
		high_acc          = 0;
		bytes_filled      = '0;
		write_slot        = '0;
		window_setting    = CFG_W'(RESET_WINDOW);
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_default_length_roll();
		test_random_lengths();
		test_output_backpressure();
		test_full_rate();

		// Drain, then watch for stray results.
		wait_for_idle();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && pending_sums.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/rawc_pkg.sv
rtl/rawc_if.sv
rtl/rawc_ring_mem.sv
rtl/rawc_ring_ctrl.sv
rtl/rawc_sum_pipe.sv
rtl/rolling_adler_window_checksum.sv
rtl/rawc_checker.sv
tb/tb_top.sv
